>>> hdl/sspm_pkg.sv
// Shared types, codes and defaults for the session slot pool hash map.
package sspm_pkg;

	localparam int SLOTS_DEF      = 256;
	localparam int BUCKETS_DEF    = 512;
	localparam int MAX_PROBES_DEF = 8;

	localparam int ADDR_W   = 48;
	localparam int HANDLE_W = 32;
	localparam int ENTRY_W  = ADDR_W + HANDLE_W;

	// address is folded into the remainder one nibble per step
	localparam int HASH_STEPS = ADDR_W / 4;

	// generation a slot carries after its first (and only) acquire
	localparam logic [15:0] GEN_FIRST = 16'd1;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_PROBE = 2'd2,
		STS_DUP   = 2'd3
	} sspm_status_t;

	typedef enum logic [0:0] {
		REQ_ACQUIRE = 1'b0,
		REQ_LOOKUP  = 1'b1
	} sspm_req_t;

	typedef enum logic [2:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_HASH,
		FSM_START,
		FSM_PROBE,
		FSM_DONE
	} sspm_state_t;

endpackage

>>> hdl/sspm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module sspm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hdl/session_slot_pool_hash_map_core.sv
// Top level: slot pool plus linear-probing address map in one bucket RAM.
// Sequence: acquire on a full pool goes straight to the result. Other words run
//   FSM_START, then FSM_PROBE reading P = 1..MAX_PROBES+1 buckets (one bucket RAM
//   read per cycle), after nibble-serial hashing when BUCKETS is no power of 2.
// Throughput: one request at a time; the next word is accepted as soon as the
//   result sits in the output register, even while that result is stalled.
// Reset: asynchronous, active low; a clearing pass then empties the bucket RAM,
//   with req_stall high until it completes.
module session_slot_pool_hash_map_core #(
	parameter int SLOTS      = sspm_pkg::SLOTS_DEF,
	parameter int BUCKETS    = sspm_pkg::BUCKETS_DEF,
	parameter int MAX_PROBES = sspm_pkg::MAX_PROBES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        req_type,
	input  logic [47:0] address,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [31:0] handle,
	output logic        found,
	output logic [1:0]  status
);

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int BKT_W  = $clog2(BUCKETS);
	localparam int PRB_W  = $clog2(MAX_PROBES + 1);
	localparam int TW     = BKT_W + 4;
	localparam int HCNT_W = $clog2(sspm_pkg::HASH_STEPS);
	localparam bit BKT_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
	localparam logic [BKT_W-1:0]  BKT_LAST  = BKT_W'(BUCKETS - 1);
	localparam logic [PRB_W-1:0]  PRB_LAST  = PRB_W'(MAX_PROBES);
	localparam logic [HCNT_W-1:0] HASH_LAST = HCNT_W'(sspm_pkg::HASH_STEPS - 1);
	localparam logic [TW-1:0]     BKT_C     = TW'(BUCKETS);

	sspm_pkg::sspm_state_t state_q, state_d;

	// control registers
	logic [SLOT_W-1:0] free_head_q;   // free list head; list is i -> i+1, never refilled
	logic [BKT_W-1:0]  clr_q;         // clearing pass pointer
	logic              rsp_valid_q;

	// request context
	logic              type_q;
	logic [47:0]       addr_q;
	logic [31:0]       hnd_q;         // handle being inserted
	logic [BKT_W-1:0]  bkt_q;         // bucket whose RAM data is on rdata in FSM_PROBE
	logic [PRB_W-1:0]  prb_q;         // probe offset of bkt_q
	logic [BKT_W-1:0]  rem_q;         // running remainder of address mod BUCKETS
	logic [47:0]       sh_q;          // address, shifted out one nibble per step
	logic [HCNT_W-1:0] hcnt_q;

	// finished result, waiting for the output register
	logic [31:0]                res_handle_q;
	logic                       res_found_q;
	sspm_pkg::sspm_status_t     res_status_q;

	// output register
	logic [31:0]                handle_q;
	logic                       found_q;
	sspm_pkg::sspm_status_t     status_q;

	// bucket RAM ports
	logic                         ram_we, ram_re;
	logic [BKT_W-1:0]             ram_waddr, ram_raddr;
	logic [sspm_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

	// datapath decisions
	logic              req_acc;
	logic              out_free;
	logic [BKT_W-1:0]  bkt_nxt;
	logic [BKT_W-1:0]  rem_nxt;
	logic [31:0]       ent_hnd;
	logic [47:0]       ent_key;
	logic              ent_used;
	logic              prb_last;
	logic              prb_end;     // request resolved at this bucket
	logic              res_load;
	logic [31:0]       res_handle_d;
	logic              res_found_d;
	sspm_pkg::sspm_status_t res_status_d;

	assign req_stall = (state_q != sspm_pkg::FSM_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign bkt_nxt  = (bkt_q == BKT_LAST) ? '0 : bkt_q + 1'b1;
	assign ent_hnd  = ram_rdata[31:0];
	assign ent_key  = ram_rdata[sspm_pkg::ENTRY_W-1:32];
	assign ent_used = (ent_hnd != 32'd0);
	assign prb_last = (prb_q == PRB_LAST);

	// one restoring step of remainder update: rem = (rem*16 + nibble) mod BUCKETS
	always_comb begin
		logic [TW-1:0] t;
		t = {rem_q, sh_q[47:44]};
		for (int j = 3; j >= 0; j--) begin
			if (t >= (BKT_C << j)) begin
				t = t - (BKT_C << j);
			end
		end
		rem_nxt = t[BKT_W-1:0];
	end

	// next state, RAM control, result formation
	always_comb begin
		state_d      = state_q;
		ram_we       = 1'b0;
		ram_waddr    = bkt_q;
		ram_wdata    = {addr_q, hnd_q};
		ram_re       = 1'b0;
		ram_raddr    = bkt_q;
		prb_end      = 1'b0;
		res_load     = 1'b0;
		res_handle_d = hnd_q;
		res_found_d  = 1'b1;
		res_status_d = sspm_pkg::STS_OK;

		case (state_q)
			sspm_pkg::FSM_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == BKT_LAST) begin
					state_d = sspm_pkg::FSM_IDLE;
				end
			end
			sspm_pkg::FSM_IDLE: begin
				if (req_acc) begin
					if (req_type == sspm_pkg::REQ_ACQUIRE && free_head_q == '0) begin
						res_load     = 1'b1;
						res_handle_d = 32'd0;
						res_found_d  = 1'b0;
						res_status_d = sspm_pkg::STS_FULL;
						state_d      = sspm_pkg::FSM_DONE;
					end else if (BKT_POW2) begin
						state_d = sspm_pkg::FSM_START;
					end else begin
						state_d = sspm_pkg::FSM_HASH;
					end
				end
			end
			sspm_pkg::FSM_HASH: begin
				if (hcnt_q == HASH_LAST) begin
					state_d = sspm_pkg::FSM_START;
				end
			end
			sspm_pkg::FSM_START: begin
				ram_re  = 1'b1;
				state_d = sspm_pkg::FSM_PROBE;
			end
			sspm_pkg::FSM_PROBE: begin
				if (type_q == sspm_pkg::REQ_ACQUIRE) begin
					if (!ent_used) begin
						ram_we  = 1'b1;
						prb_end = 1'b1;
					end else if (prb_last) begin
						res_status_d = sspm_pkg::STS_PROBE;
						prb_end      = 1'b1;
					end else if (ent_hnd == hnd_q) begin
						res_status_d = sspm_pkg::STS_DUP;
						prb_end      = 1'b1;
					end
				end else begin
					if (ent_used && ent_key == addr_q) begin
						res_handle_d = ent_hnd;
						prb_end      = 1'b1;
					end else if (prb_last) begin
						res_handle_d = 32'd0;
						res_found_d  = 1'b0;
						prb_end      = 1'b1;
					end
				end
				if (prb_end) begin
					res_load = 1'b1;
					state_d  = sspm_pkg::FSM_DONE;
				end else begin
					// fetch the following bucket while this one is judged
					ram_re    = 1'b1;
					ram_raddr = bkt_nxt;
				end
			end
			sspm_pkg::FSM_DONE: begin
				if (out_free) begin
					state_d = sspm_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = sspm_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sspm_pkg::FSM_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= SLOT_W'(1);
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == sspm_pkg::FSM_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (req_acc && req_type == sspm_pkg::REQ_ACQUIRE && free_head_q != '0) begin
				free_head_q <= (free_head_q == SLOT_LAST) ? '0 : free_head_q + 1'b1;
			end
			if (state_q == sspm_pkg::FSM_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request context and result payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			type_q <= req_type;
			addr_q <= address;
			sh_q   <= address;
			hnd_q  <= {sspm_pkg::GEN_FIRST, 16'(free_head_q)};
			rem_q  <= '0;
			hcnt_q <= '0;
			prb_q  <= '0;
			bkt_q  <= address[BKT_W-1:0];
		end
		if (state_q == sspm_pkg::FSM_HASH) begin
			rem_q  <= rem_nxt;
			sh_q   <= {sh_q[43:0], 4'h0};
			hcnt_q <= hcnt_q + 1'b1;
			bkt_q  <= rem_nxt;
		end
		if (state_q == sspm_pkg::FSM_PROBE && !prb_end) begin
			bkt_q <= bkt_nxt;
			prb_q <= prb_q + 1'b1;
		end
		if (res_load) begin
			res_handle_q <= res_handle_d;
			res_found_q  <= res_found_d;
			res_status_q <= res_status_d;
		end
		if (state_q == sspm_pkg::FSM_DONE && out_free) begin
			handle_q <= res_handle_q;
			found_q  <= res_found_q;
			status_q <= res_status_q;
		end
	end

	sspm_ram #(
		.WIDTH(sspm_pkg::ENTRY_W),
		.DEPTH(BUCKETS)
	) u_bucket_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rsp_valid = rsp_valid_q;
	assign handle    = handle_q;
	assign found     = found_q;
	assign status    = status_q;

endmodule

>>> hdl/sspm_checker.sv
// Port-level checker for the session slot pool hash map, bound to the top level.
module sspm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [31:0] handle,
	input logic        found,
	input logic [1:0]  status
);

	// a stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(handle) && $stable(found)
			&& $stable(status))
		else $error("stalled result word changed");

	// found tracks a nonzero handle
	a_found_handle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (found == (handle != 32'd0)))
		else $error("found disagrees with handle");

	// a full pool hands out nothing
	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == sspm_pkg::STS_FULL |-> !found && handle == 32'd0)
		else $error("pool full answer carries a handle");

	// handles out of the pool carry the first generation and never slot 0
	a_handle_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && found |-> handle[31:16] == sspm_pkg::GEN_FIRST
			&& handle[15:0] != 16'd0)
		else $error("malformed handle");

	// one request at a time: an accepted word blocks the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while busy");

endmodule

bind session_slot_pool_hash_map_core sspm_checker u_sspm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.handle   (handle),
	.found    (found),
	.status   (status)
);
